// ----- sv/pmrr_pkg.sv -----
// ----------------------------------------------------------------------------
// pmrr_pkg
// Shared constants and the request item type for the range random unit.
// ----------------------------------------------------------------------------
package pmrr_pkg;

  localparam int SeedW  = 31;
  localparam int ValW   = 32;
  localparam int SpanW  = 33;
  localparam int MultW  = 15;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic [MultW-1:0] Multiplier = 15'd16807;
  localparam logic [SeedW-1:0] Modulus    = 31'h7FFF_FFFF;

  // One classified request handed from front to back.
  typedef struct packed {
    logic [ValW-1:0]  low;
    logic [SpanW-1:0] span;
    logic [SeedW-1:0] seed;
    logic             err;
  } item_t;

endpackage

// ----- sv/pmrr_front.sv -----
// ----------------------------------------------------------------------------
// pmrr_front
// Holds the generator seed, advances it per accepted request and classifies
// the requested range into span and error flag.
// ----------------------------------------------------------------------------
module pmrr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [pmrr_pkg::ValW-1:0]   range_low,
  input  logic [pmrr_pkg::ValW-1:0]   range_high,
  input  logic                        cfg_wr_en,
  input  logic [pmrr_pkg::SeedW-1:0]  cfg_wr_data,
  output pmrr_pkg::item_t             item
);

  logic [pmrr_pkg::SeedW-1:0] seed_r;
  logic [pmrr_pkg::SeedW-1:0] seed_nxt;
  logic [45:0]                prod;
  logic [31:0]                fold;
  logic [pmrr_pkg::ValW-1:0]  low_ob;
  logic [pmrr_pkg::ValW-1:0]  high_ob;

  // seed * 16807 mod (2^31-1): fold the high part onto the low part
  assign prod = 46'(seed_r) * 46'(pmrr_pkg::Multiplier);
  assign fold = {17'b0, prod[45:31]} + {1'b0, prod[30:0]};
  assign seed_nxt = (fold >= {1'b0, pmrr_pkg::Modulus}) ?
                    31'(fold - {1'b0, pmrr_pkg::Modulus}) : fold[30:0];

  // offset binary turns signed order into unsigned order
  assign low_ob  = range_low  ^ 32'h8000_0000;
  assign high_ob = range_high ^ 32'h8000_0000;

  always_comb begin
    item.low  = range_low;
    item.seed = seed_nxt;
    item.err  = high_ob < low_ob;
    item.span = {1'b0, high_ob} - {1'b0, low_ob} + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 31'd1;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end else if (accept) begin
      seed_r <= seed_nxt;
    end
  end

endmodule

// ----- sv/pmrr_queue.sv -----
// ----------------------------------------------------------------------------
// pmrr_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module pmrr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pmrr_pkg::item_t push_data,
  input  logic            pop,
  output pmrr_pkg::item_t pop_data,
  output logic            full,
  output logic            empty
);

  pmrr_pkg::item_t              mem_r [pmrr_pkg::QDepth];
  logic [pmrr_pkg::QPtrW-1:0]   wr_ptr_r;
  logic [pmrr_pkg::QPtrW-1:0]   rd_ptr_r;
  logic [pmrr_pkg::QCntW-1:0]   count_r;
  logic [pmrr_pkg::QCntW-1:0]   count_nxt;

  assign full     = count_r == pmrr_pkg::QCntW'(pmrr_pkg::QDepth);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + pmrr_pkg::QCntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - pmrr_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pmrr_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pmrr_pkg::QPtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pmrr_pkg::QCntW'(pmrr_pkg::QDepth))
    else $error("queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ----- sv/pmrr_back.sv -----
// ----------------------------------------------------------------------------
// pmrr_back
// Scales the seed onto the span: floor(seed*span/(2^31-1)) by a product and
// two Mersenne folds, adds the low bound and holds the result beat.
// ----------------------------------------------------------------------------
module pmrr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  pmrr_pkg::item_t             q_data,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [pmrr_pkg::ValW-1:0]   out_pick,
  output logic [pmrr_pkg::SeedW-1:0]  out_frac,
  output logic                        out_err
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FOLD,
    S_QUOT,
    S_PICK
  } state_t;

  state_t                     state_r;
  pmrr_pkg::item_t            op_r;
  logic [62:0]                prod_r;
  logic [62:0]                prod_nxt;
  logic [31:0]                q0_r;
  logic [32:0]                r0_r;
  logic [32:0]                r0_nxt;
  logic [31:0]                q_r;
  logic [31:0]                q_nxt;
  logic [31:0]                r1;
  logic [1:0]                 carry;
  logic                       ge;
  logic                       out_valid_r;
  logic [pmrr_pkg::ValW-1:0]  out_pick_r;
  logic [pmrr_pkg::ValW-1:0]  pick_nxt;
  logic [pmrr_pkg::SeedW-1:0] out_frac_r;
  logic                       out_err_r;
  logic                       out_take;

  assign out_take  = out_pop && out_valid_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty && (!out_valid_r || out_take);
  assign out_empty = !out_valid_r;
  assign out_pick  = out_pick_r;
  assign out_frac  = out_frac_r;
  assign out_err   = out_err_r;

  // span of exactly 2^32 has zero low bits: product is a plain shift
  assign prod_nxt = op_r.span[32] ? {op_r.seed, 32'b0} :
                    63'(op_r.seed) * 63'(op_r.span[31:0]);

  // P = q0*2^31 + b  ->  P = q0*M + (q0 + b)
  assign r0_nxt = {1'b0, prod_r[62:31]} + {2'b0, prod_r[30:0]};

  assign carry = r0_r[32:31];
  assign r1    = {1'b0, r0_r[30:0]} + 32'(carry);
  assign ge    = r1 >= {1'b0, pmrr_pkg::Modulus};
  assign q_nxt = q0_r + 32'(carry) + 32'(ge);

  assign pick_nxt = op_r.err ? op_r.low : op_r.low + q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            op_r    <= q_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          q0_r    <= prod_r[62:31];
          r0_r    <= r0_nxt;
          state_r <= S_QUOT;
        end
        S_QUOT: begin
          q_r     <= q_nxt;
          state_r <= S_PICK;
        end
        S_PICK: begin
          out_pick_r  <= pick_nxt;
          out_frac_r  <= op_r.seed;
          out_err_r   <= op_r.err;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_valid_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PICK))
    else $error("result beat raised outside pick step");

  a_err_pick_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_pick_r == op_r.low))
    else $error("reversed range did not return low bound");

  a_quot_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK && !op_r.err) |-> ({1'b0, q_r} < op_r.span))
    else $error("scaled offset outside span");

endmodule

// ----- sv/park_miller_range_random_unit.sv -----
// ----------------------------------------------------------------------------
// park_miller_range_random_unit
// Minimal standard generator (x16807 mod 2^31-1) with exact range scaling.
// ----------------------------------------------------------------------------
// Requests pass the queue and the back end's multiply, fold, quotient and pick
// steps to the out ports; the back end takes a new one only when idle with its
// output free. The front takes requests every cycle until the 4-deep queue
// fills. Reset (sync, active low) loads seed 1 and empties queue and output.
// ----------------------------------------------------------------------------
module park_miller_range_random_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic signed [31:0]          in_range_low,
  input  logic signed [31:0]          in_range_high,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [31:0]          out_pick_value,
  output logic [30:0]                 out_uniform_fraction,
  output logic                        out_range_error,
  input  logic                        cfg_wr_en,
  input  logic [30:0]                 cfg_wr_data
);

  pmrr_pkg::item_t            front_item;
  pmrr_pkg::item_t            q_data;
  logic                       accept;
  logic                       q_pop;
  logic                       q_empty;
  logic [pmrr_pkg::ValW-1:0]  pick;

  assign accept = in_push && !in_full;

  pmrr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .range_low   (in_range_low),
    .range_high  (in_range_high),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (front_item)
  );

  pmrr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_item),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (in_full),
    .empty     (q_empty)
  );

  pmrr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_pick  (pick),
    .out_frac  (out_uniform_fraction),
    .out_err   (out_range_error)
  );

  assign out_pick_value = $signed(pick);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range random unit: a queue-fed driver pushes
// range requests and a scoreboard model of the x16807 mod 2^31-1 generator
// with exact range scaling predicts every result beat. It covers seed reloads
// including the zero seeds, random idling on both sides and a long output
// stall that backs up the input side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 10;
  localparam int HoldCycles = 80;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 180;
  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] low;
    logic signed [31:0] high;
  } range_t;

  typedef struct packed {
    logic signed [31:0] pick;
    logic [30:0]        frac;
    logic               err;
  } draw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_range_low = '0;
  logic signed [31:0] in_range_high = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_pick_value;
  logic [30:0] out_uniform_fraction;
  logic out_range_error;
  logic cfg_wr_en = 1'b0;
  logic [30:0] cfg_wr_data = '0;

  range_t ranges_to_send[$];
  draw_t draws_due[$];
  logic [30:0] model_seed = 31'd1;
  int unsigned ranges_queued = 0;
  int unsigned ranges_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit pressure_armed = 1'b0;
  bit pressure_done = 1'b0;

  park_miller_range_random_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_range_low         (in_range_low),
    .in_range_high        (in_range_high),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_pick_value       (out_pick_value),
    .out_uniform_fraction (out_uniform_fraction),
    .out_range_error      (out_range_error),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the seed and scale it into [lo, hi].
  task automatic predict_draw(input logic signed [31:0] lo, input logic signed [31:0] hi);
    draw_t d;
    logic [32:0] span;
    logic [63:0] prod;
    logic [31:0] offset;
    model_seed = 31'((64'(model_seed) * 64'(pmrr_pkg::Multiplier)) %
                     64'(pmrr_pkg::Modulus));
    d.frac = model_seed;
    d.err = (hi < lo);
    d.pick = lo;
    if (!d.err) begin
      // offset binary makes the span an unsigned difference, 1 .. 2^32
      span = {1'b0, hi ^ 32'h8000_0000} - {1'b0, lo ^ 32'h8000_0000} + 33'd1;
      prod = 64'(model_seed) * 64'(span);
      offset = 32'(prod / 64'(pmrr_pkg::Modulus));
      d.pick = lo + offset;
    end
    draws_due.push_back(d);
  endtask

  task automatic check_draw();
    draw_t want;
    if (draws_due.size() == 0) begin
      $error("result beat with no draw pending: pick_value %0d", out_pick_value);
      mismatches++;
    end else begin
      want = draws_due.pop_front();
      if (out_pick_value !== want.pick) begin
        $error("pick_value: expected %0d, got %0d", want.pick, out_pick_value);
        mismatches++;
      end
      if (out_uniform_fraction !== want.frac) begin
        $error("uniform_fraction: expected %0d, got %0d", want.frac, out_uniform_fraction);
        mismatches++;
      end
      if (out_range_error !== want.err) begin
        $error("range_error: expected %0d, got %0d", want.err, out_range_error);
        mismatches++;
      end
    end
  endtask

  task automatic queue_range(input logic signed [31:0] lo, input logic signed [31:0] hi);
    range_t r;
    r.low = lo;
    r.high = hi;
    ranges_to_send.push_back(r);
    ranges_queued++;
  endtask

  task automatic queue_random_range();
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(0, 6))
      1: hi = lo + $urandom_range(0, 15);
      2: begin
        lo = IntMin + $urandom_range(0, 3);
        hi = IntMax - $urandom_range(0, 3);
      end
      3: hi = lo - $urandom_range(1, 100);
      4: hi = lo;
      5, 6: begin
        lo = $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
        hi = lo + $urandom_range(0, 1 << 20);
      end
      default: ;
    endcase
    queue_range(lo, hi);
  endtask

  task automatic write_seed(input logic [30:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_seed = value;
  endtask

  // Wait until every queued request is taken and answered, then let the
  // pipeline settle.
  task automatic drain();
    while (ranges_accepted != ranges_queued || draws_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Driver: holds a beat while full, otherwise idles or sends the next one.
  always @(posedge clk) begin
    range_t req;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_draw(in_range_low, in_range_high);
        ranges_accepted++;
      end
      if (in_push && in_full) begin
        // keep offering the same beat
      end else if (push_gap != 0) begin
        push_gap--;
        in_push <= 1'b0;
      end else if (ranges_to_send.size() != 0) begin
        req = ranges_to_send.pop_front();
        in_range_low <= req.low;
        in_range_high <= req.high;
        in_push <= 1'b1;
        if (send_idle_on && $urandom_range(0, 4) == 0) push_gap = $urandom_range(1, 11);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor and receiver: checks beats, stalls in bursts, one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_draw();
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pressure_armed && !pressure_done && !out_empty) begin
        pressure_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 3) == 0) pop_gap = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed, edge ranges
    queue_range(0, 0);
    queue_range(IntMin, IntMax);
    queue_range(IntMax, IntMin);
    queue_range(IntMax, IntMax);
    queue_range(IntMin, IntMin);
    queue_range(0, 1);
    queue_range(-1, 0);
    queue_range(5, 4);
    queue_range(IntMin, IntMin + 1);
    queue_range(IntMax - 1, IntMax);
    queue_range(0, IntMax);
    queue_range(IntMin, -1);
    queue_range(-100, 100);
    drain();

    write_seed(31'd2147483646);
    queue_range(IntMin, IntMax);
    queue_range(0, 9);
    queue_range(3, -3);
    queue_range(-1, -1);
    drain();

    // zero and modulus seeds lock the generator at zero
    write_seed(31'd0);
    queue_range(IntMin, IntMax);
    queue_range(7, 1000);
    queue_range(1, 0);
    drain();

    write_seed(31'h7FFF_FFFF);
    queue_range(IntMin, IntMax);
    queue_range(-50, 50);
    queue_range(IntMax, IntMin);
    drain();

    write_seed(31'd1);
    queue_range(IntMin, IntMax);
    queue_range(1, 6);
    drain();

    for (ph = 0; ph < RandPhases; ph++) begin
      write_seed(31'($urandom_range(1, 2147483646)));
      send_idle_on = (ph != RandPhases - 1) && (ph != 2);
      recv_idle_on = (ph != RandPhases - 1);
      pressure_armed = (ph == 2);
      repeat (PhaseItems) queue_random_range();
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
